// ===== rtl/core/lbfv_pkg.sv =====
// Shared types, constants and saturating helpers for the four-vector boost.
// No dependencies; lbfv_mul, lbfv_sqrt, the top level and the testbench import this package.
package lbfv_pkg;

  typedef logic signed [63:0] s64_t;

  // Result status codes.
  localparam logic [1:0] ST_BOOST = 2'd0;
  localparam logic [1:0] ST_IDENT = 2'd1;
  localparam logic [1:0] ST_LIGHT = 2'd2;

  // Latencies of the arithmetic units, in register stages.
  localparam int MUL_LAT    = 5;
  localparam int SQRT_STEPS = 32;
  localparam int G_QW       = 61;  // quotient bits of 2^62 / S
  localparam int GG_QW      = 30;  // quotient bits of 2^60 / (G + 2^30)

  localparam s64_t S64_MAX = {1'b0, {63{1'b1}}};
  localparam s64_t S64_MIN = {1'b1, {63{1'b0}}};

  // Signed 64-bit add that clips to the signed range.
  function automatic s64_t sadd64(input s64_t a, input s64_t b);
    s64_t s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  // Two's complement negate; the most negative value wraps onto itself.
  function automatic s64_t neg64(input s64_t a);
    return ~a + 64'sd1;
  endfunction

endpackage

// ===== rtl/core/lbfv_dly.sv =====
// Enable-gated delay line for payload that rides alongside the arithmetic.
// Depends on nothing; control valid bits live in the top level.
module lbfv_dly #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// ===== rtl/core/lbfv_mul.sv =====
// Pipelined signed 64x64 multiply, result shifted right by 30 with rounding
// half away from zero and clipped to +-(2^63-1). Uses lbfv_pkg.
module lbfv_mul import lbfv_pkg::*; (
  input  logic clk,
  input  logic en,
  input  s64_t a,
  input  s64_t b,
  output s64_t prod
);

  logic [3:0]  neg_r;
  logic [63:0] ma_r, mb_r;
  logic [63:0] ll_r, m1_r, m2_r, hh_r;
  logic [33:0] t_r;
  logic [63:0] hsum_r;
  logic [31:0] lllo_r;
  logic [63:0] hi_r;
  logic [33:0] lohi_r;
  s64_t        prod_r;

  logic [64:0] lo_sum;
  logic [63:0] mag_res;
  logic        sat;

  assign lo_sum  = {1'b0, t_r[31:0], lllo_r} + 65'(64'd1 << 29);
  assign sat     = |hi_r[63:29];
  assign mag_res = sat ? 64'(S64_MAX) : {1'b0, hi_r[28:0], lohi_r};

  always_ff @(posedge clk) begin
    if (en) begin
      // Sign and magnitudes.
      neg_r[0] <= a[63] ^ b[63];
      ma_r     <= a[63] ? (~a + 64'd1) : a;
      mb_r     <= b[63] ? (~b + 64'd1) : b;
      // Partial products.
      neg_r[1] <= neg_r[0];
      ll_r     <= ma_r[31:0]  * mb_r[31:0];
      m1_r     <= ma_r[31:0]  * mb_r[63:32];
      m2_r     <= ma_r[63:32] * mb_r[31:0];
      hh_r     <= ma_r[63:32] * mb_r[63:32];
      // Middle column and upper word.
      neg_r[2] <= neg_r[1];
      t_r      <= 34'(ll_r[63:32]) + 34'(m1_r[31:0]) + 34'(m2_r[31:0]);
      hsum_r   <= hh_r + 64'(m1_r[63:32]) + 64'(m2_r[63:32]);
      lllo_r   <= ll_r[31:0];
      // Rounding constant and carry into the upper word.
      neg_r[3] <= neg_r[2];
      hi_r     <= hsum_r + 64'(t_r[33:32]) + 64'(lo_sum[64]);
      lohi_r   <= lo_sum[63:30];
      // Clip and restore the sign.
      prod_r   <= neg_r[3] ? neg64(s64_t'(mag_res)) : s64_t'(mag_res);
    end
  end

  assign prod = prod_r;

endmodule

// ===== rtl/core/lbfv_sqrt.sv =====
// Pipelined 64-bit integer square root, one result bit per stage.
// Uses SQRT_STEPS from lbfv_pkg.
module lbfv_sqrt import lbfv_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  output logic [31:0] root
);

  logic [63:0] rem_r [SQRT_STEPS];
  logic [63:0] res_r [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] rem_in, res_in, trial;

    if (i == 0) begin : g_first
      assign rem_in = n;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign res_in = res_r[i-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[i] <= rem_in - trial;
          res_r[i] <= (res_in >> 1) + BIT;
        end else begin
          rem_r[i] <= rem_in;
          res_r[i] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_r[SQRT_STEPS-1][31:0];

endmodule

// ===== rtl/core/lbfv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage. The dividend's
// low bits are zero; only its top part enters as the starting remainder.
module lbfv_div #(
  parameter int DEN_W = 32,
  parameter int Q_W   = 61
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] rem0,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [DEN_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    logic [DEN_W-1:0] rem_in, den_in;
    logic [Q_W-1:0]   q_in;
    logic [DEN_W:0]   r2, diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = rem0;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign r2   = {rem_in, 1'b0};
    assign ge   = r2 >= {1'b0, den_in};
    assign diff = r2 - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
        den_r[j] <= den_in;
        q_r[j]   <= {q_in[Q_W-2:0], ge};
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

// ===== rtl/core/lorentz_boost_four_vector.sv =====
// Lorentz boost of a Q16.16 four-vector by a Q2.30 velocity, fully pipelined.
// Depends on lbfv_pkg, lbfv_dly, lbfv_mul, lbfv_sqrt and lbfv_div.
//
// Usage:
//   An item on the input channel carries a velocity (in_vel_x/y/z, signed
//   Q2.30 fraction of light speed) and a four-vector (in_t, in_x, in_y, in_z,
//   signed Q16.16). Each item produces exactly one result item on the output
//   channel: the boosted vector, a status (boosted, zero velocity pass or
//   speed not below light with zero outputs) and a flag set when any output
//   component was clipped to the COMPONENT_WIDTH range.
//   Throughput is one item per clock cycle while the output side does not
//   stall. The pipeline depth is set by the 32-stage square root and the
//   61- and 30-stage dividers that form gamma and (gamma-1)/b, followed by
//   two rounds of 5-stage multipliers.
//   Valid bits travel with the data. When the output register holds an
//   unaccepted item and the last pipeline stage is also full, the whole
//   pipeline freezes and in_ready drops; bubbles in flight still let new
//   items enter while a result waits. Reset empties the pipeline and the
//   output register; there is no other state.
module lorentz_boost_four_vector import lbfv_pkg::*; #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_vel_x,
  input  logic signed [31:0]                in_vel_y,
  input  logic signed [31:0]                in_vel_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_t,
  input  logic signed [COMPONENT_WIDTH-1:0] in_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COMPONENT_WIDTH-1:0] out_t,
  output logic signed [COMPONENT_WIDTH-1:0] out_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_z,
  output logic [1:0]                        out_status,
  output logic                              out_saturated
);

  localparam int W = COMPONENT_WIDTH;

  // Stage numbers: the register count from the accepting edge.
  localparam int ST_STAT = 3;                       // b and status
  localparam int ST_N    = 4;                       // sqrt operand
  localparam int ST_S    = ST_N + SQRT_STEPS;       // sqrt(1-b)
  localparam int ST_G    = ST_S + G_QW;             // gamma
  localparam int ST_D    = ST_G + 1;                // gamma + 1
  localparam int ST_Q2   = ST_D + GG_QW;            // 1/(gamma+1)
  localparam int ST_GG   = ST_Q2 + 1;               // (gamma-1)/b
  localparam int ST_P    = MUL_LAT + 2;             // v.x
  localparam int ST_C1   = ST_GG + 1;               // t - p
  localparam int ST_M1   = ST_C1 + MUL_LAT;         // first products
  localparam int ST_K    = ST_M1 + 1;               // k
  localparam int ST_M2   = ST_K + MUL_LAT;          // k * v
  localparam int ST_SEL  = ST_M2 + 1;               // result select
  localparam int LAST    = ST_SEL + 1;              // clip

  localparam int PAY_W = 3 * 32 + 4 * W;
  localparam s64_t OUT_MAX = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam s64_t OUT_MIN = -OUT_MAX - 64'sd1;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  logic en;
  logic [LAST:1] vld_r;

  // Output register handshake.
  logic            out_valid_r;
  logic [W-1:0]    ot_r, ox_r, oy_r, oz_r;
  logic [1:0]      ost_r;
  logic            osat_r;

  assign en       = !vld_r[LAST] || !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:1], in_valid};
    end
  end

  // Velocity magnitude squared and status.
  logic [31:0] mag_r [3];
  logic [63:0] sq_r  [3];
  logic [63:0] b_r;
  logic [1:0]  st_r;
  logic [63:0] n_r;
  logic [63:0] b_sum;
  logic signed [31:0] vin [3];

  assign vin[0] = in_vel_x;
  assign vin[1] = in_vel_y;
  assign vin[2] = in_vel_z;
  assign b_sum  = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= vin[i][31] ? (~vin[i] + 32'd1) : vin[i];
        sq_r[i]  <= mag_r[i] * mag_r[i];
      end
      b_r <= b_sum;
      if (b_sum == 64'd0) begin
        st_r <= ST_IDENT;
      end else if (|b_sum[63:60]) begin
        st_r <= ST_LIGHT;
      end else begin
        st_r <= ST_BOOST;
      end
      // (2^60 - b) << 4, the squared Q0.32 operand of sqrt(1-b).
      n_r <= ((64'd1 << 60) - b_r) << 4;
    end
  end

  // gamma = 2^62 / sqrt(1-b) and 1/(gamma+1) = 2^60 / (gamma + 2^30).
  logic [31:0]     s_root;
  logic [G_QW-1:0] g_q;
  logic [G_QW-1:0] g_d_r;
  logic [G_QW-1:0] g_late;
  logic [G_QW-1:0] q2_den;
  logic [GG_QW-1:0] q2;
  s64_t            g129_r, gg129_r;

  lbfv_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (n_r),
    .root (s_root)
  );

  lbfv_div #(.DEN_W(32), .Q_W(G_QW)) u_div_g (
    .clk  (clk),
    .en   (en),
    .rem0 (32'd2),
    .den  (s_root),
    .quo  (g_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      g_d_r <= g_q + G_QW'(ONE_Q30);
    end
  end

  assign q2_den = g_d_r;

  lbfv_div #(.DEN_W(G_QW), .Q_W(GG_QW)) u_div_gg (
    .clk  (clk),
    .en   (en),
    .rem0 (G_QW'(ONE_Q30)),
    .den  (q2_den),
    .quo  (q2)
  );

  lbfv_dly #(.WIDTH(G_QW), .DEPTH(ST_Q2 - ST_G)) u_dly_g (
    .clk (clk),
    .en  (en),
    .d   (g_q),
    .q   (g_late)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      g129_r  <= s64_t'(64'(g_late));
      gg129_r <= s64_t'(64'(g_late) - ONE_Q30 + 64'(q2));
    end
  end

  // Dot product p = v . x, started straight from the ports.
  s64_t pv [3];
  s64_t p01_r, pv2_r, p_r, p129;
  s64_t xin [4];

  assign xin[0] = 64'(in_t);
  assign xin[1] = 64'(in_x);
  assign xin[2] = 64'(in_y);
  assign xin[3] = 64'(in_z);

  for (genvar i = 0; i < 3; i++) begin : g_dot
    lbfv_mul u_mul (
      .clk  (clk),
      .en   (en),
      .a    (64'(vin[i])),
      .b    (xin[i+1]),
      .prod (pv[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p01_r <= sadd64(pv[0], pv[1]);
      pv2_r <= pv[2];
      p_r   <= sadd64(p01_r, pv2_r);
    end
  end

  lbfv_dly #(.WIDTH(64), .DEPTH(ST_GG - ST_P)) u_dly_p (
    .clk (clk),
    .en  (en),
    .d   (p_r),
    .q   (p129)
  );

  // Input payload carried to the boost stages.
  logic [PAY_W-1:0] pay129;
  logic [95:0]      v136;
  logic [4*W-1:0]   x141;
  s64_t             x0_129;

  lbfv_dly #(.WIDTH(PAY_W), .DEPTH(ST_GG)) u_dly_pay (
    .clk (clk),
    .en  (en),
    .d   ({in_vel_x, in_vel_y, in_vel_z, in_t, in_x, in_y, in_z}),
    .q   (pay129)
  );

  assign x0_129 = 64'(signed'(pay129[4*W-1:3*W]));

  lbfv_dly #(.WIDTH(96), .DEPTH(ST_K - ST_GG)) u_dly_v (
    .clk (clk),
    .en  (en),
    .d   (pay129[PAY_W-1:4*W]),
    .q   (v136)
  );

  lbfv_dly #(.WIDTH(4 * W), .DEPTH(ST_M2 - ST_GG)) u_dly_x (
    .clk (clk),
    .en  (en),
    .d   (pay129[4*W-1:0]),
    .q   (x141)
  );

  // t - p and the first round of products.
  s64_t tp_r, g130_r, gg130_r, p130_r, x0130_r;
  s64_t m_t, m_gp, m_gt;

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r    <= sadd64(x0_129, neg64(p129));
      g130_r  <= g129_r;
      gg130_r <= gg129_r;
      p130_r  <= p129;
      x0130_r <= x0_129;
    end
  end

  lbfv_mul u_mul_t (
    .clk (clk), .en (en), .a (g130_r), .b (tp_r), .prod (m_t)
  );

  lbfv_mul u_mul_gp (
    .clk (clk), .en (en), .a (gg130_r), .b (p130_r), .prod (m_gp)
  );

  lbfv_mul u_mul_gt (
    .clk (clk), .en (en), .a (g130_r), .b (x0130_r), .prod (m_gt)
  );

  // k = gg*p - gamma*t, then k * v for the spatial components.
  s64_t k_r;
  s64_t mk [3];
  s64_t r0_141;

  always_ff @(posedge clk) begin
    if (en) begin
      k_r <= sadd64(m_gp, neg64(m_gt));
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_kv
    lbfv_mul u_mul (
      .clk  (clk),
      .en   (en),
      .a    (k_r),
      .b    (64'(signed'(v136[95-32*i -: 32]))),
      .prod (mk[i])
    );
  end

  lbfv_dly #(.WIDTH(64), .DEPTH(ST_M2 - ST_M1)) u_dly_r0 (
    .clk (clk),
    .en  (en),
    .d   (m_t),
    .q   (r0_141)
  );

  // Status rides from the magnitude stage to the select stage.
  logic [1:0] st141;

  lbfv_dly #(.WIDTH(2), .DEPTH(ST_M2 - ST_STAT)) u_dly_st (
    .clk (clk),
    .en  (en),
    .d   (st_r),
    .q   (st141)
  );

  // Select the boosted, passed-through or zeroed result.
  s64_t       res_r [4];
  logic [1:0] st142_r;
  s64_t       xe [4];

  for (genvar i = 0; i < 4; i++) begin : g_xe
    assign xe[i] = 64'(signed'(x141[4*W-1-W*i -: W]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st142_r <= st141;
      case (st141)
        ST_IDENT: begin
          for (int i = 0; i < 4; i++) res_r[i] <= xe[i];
        end
        ST_LIGHT: begin
          for (int i = 0; i < 4; i++) res_r[i] <= '0;
        end
        default: begin
          res_r[0] <= r0_141;
          for (int i = 0; i < 3; i++) res_r[i+1] <= sadd64(xe[i+1], mk[i]);
        end
      endcase
    end
  end

  // Clip to the component range.
  logic [W-1:0] clip_r [4];
  logic [1:0]   st143_r;
  logic         csat_r;
  logic [W-1:0] clip_nxt [4];
  logic         csat_nxt;

  always_comb begin
    csat_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (res_r[i] > OUT_MAX) begin
        clip_nxt[i] = OUT_MAX[W-1:0];
        csat_nxt    = 1'b1;
      end else if (res_r[i] < OUT_MIN) begin
        clip_nxt[i] = OUT_MIN[W-1:0];
        csat_nxt    = 1'b1;
      end else begin
        clip_nxt[i] = res_r[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_r  <= clip_nxt;
      csat_r  <= csat_nxt;
      st143_r <= st142_r;
    end
  end

  // Output register: takes the last stage whenever it is empty or drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      ot_r   <= clip_r[0];
      ox_r   <= clip_r[1];
      oy_r   <= clip_r[2];
      oz_r   <= clip_r[3];
      ost_r  <= st143_r;
      osat_r <= csat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_t         = ot_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;
  assign out_status    = ost_r;
  assign out_saturated = osat_r;

endmodule

// ===== tb/tb_lorentz_boost_four_vector.sv =====
// Self-checking testbench for lorentz_boost_four_vector: random and directed boosts
// checked against an in-bench fixed-point boost calculation. Depends on lbfv_pkg.
`timescale 1ns / 100ps

module tb_lorentz_boost_four_vector;
  import lbfv_pkg::*;

  // One input item: a velocity and a four-vector.
  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic signed [31:0] t, x, y, z;
  } boost_in_t;

  // One result item as the block should present it.
  typedef struct {
    logic signed [31:0] t, x, y, z;
    logic [1:0]         status;
    logic               sat;
  } boost_out_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic signed [31:0] in_vel_x, in_vel_y, in_vel_z;
  logic signed [31:0] in_t, in_x, in_y, in_z;
  logic out_valid, out_ready;
  logic signed [31:0] out_t, out_x, out_y, out_z;
  logic [1:0] out_status;
  logic out_saturated;

  boost_in_t  pending_items[$];
  boost_out_t expected_boosts[$];
  int         mismatches = 0;
  bit         finale = 0;       // no new idle gaps or stalls start once set
  int         send_gap = 0;
  int         stall_left = 0;

  lorentz_boost_four_vector #(.COMPONENT_WIDTH(32)) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_vel_x     (in_vel_x),
    .in_vel_y     (in_vel_y),
    .in_vel_z     (in_vel_z),
    .in_t         (in_t),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_t        (out_t),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_status   (out_status),
    .out_saturated(out_saturated)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Product of two Q.30-scaled values, rounded half away from zero and clipped
  // to +-(2^63-1). The exact product needs 128 bits.
  function automatic s64_t q30_product(input s64_t a, input s64_t b);
    logic [63:0]  ma, mb;
    logic [127:0] prod;
    s64_t         r;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    prod = {64'd0, ma} * {64'd0, mb};
    prod = (prod + (128'd1 << 29)) >> 30;
    if (prod > {64'd0, 64'h7FFF_FFFF_FFFF_FFFF}) begin
      r = S64_MAX;
    end else begin
      r = prod[63:0];
    end
    return (a[63] != b[63]) ? -r : r;
  endfunction

  function automatic s64_t clamp_sum(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
    return s[63:0];
  endfunction

  // Floor of the square root, one result bit at a time.
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= {64'd0, n}) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clip32(input s64_t v, inout logic sat);
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Expected result of boosting one item.
  function automatic boost_out_t boost_vector(input boost_in_t it);
    s64_t        v[3], x[3], res[4];
    logic [63:0] mg, speed_sq, root, gam, gam_tail;
    s64_t        dot, kick, t;
    boost_out_t  o;
    v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
    x[0] = it.x;  x[1] = it.y;  x[2] = it.z;
    t = it.t;
    speed_sq = '0;
    for (int i = 0; i < 3; i++) begin
      mg = v[i][63] ? 64'(-v[i]) : 64'(v[i]);
      speed_sq += mg * mg;
    end
    o.sat = 1'b0;
    if (speed_sq == 0) begin
      o.status = ST_IDENT;
      res[0] = t; res[1] = x[0]; res[2] = x[1]; res[3] = x[2];
    end else if (speed_sq >= (64'd1 << 60)) begin
      o.status = ST_LIGHT;
      res[0] = 0; res[1] = 0; res[2] = 0; res[3] = 0;
    end else begin
      o.status = ST_BOOST;
      // sqrt(1-b) in Q0.32, gamma in Q.30, (gamma-1)/b in Q.30.
      root = floor_root(((64'd1 << 60) - speed_sq) << 4);
      gam = (64'd1 << 62) / root;
      gam_tail = gam - (64'd1 << 30) + (64'd1 << 60) / (gam + (64'd1 << 30));
      dot = 0;
      for (int i = 0; i < 3; i++) dot = clamp_sum(dot, q30_product(v[i], x[i]));
      res[0] = q30_product(s64_t'(gam), clamp_sum(t, -dot));
      kick = clamp_sum(q30_product(s64_t'(gam_tail), dot), -q30_product(s64_t'(gam), t));
      for (int i = 0; i < 3; i++) res[i + 1] = clamp_sum(x[i], q30_product(kick, v[i]));
    end
    o.t = clip32(res[0], o.sat);
    o.x = clip32(res[1], o.sat);
    o.y = clip32(res[2], o.sat);
    o.z = clip32(res[3], o.sat);
    return o;
  endfunction

  task automatic add_item(input logic [31:0] vx, vy, vz, t, x, y, z);
    boost_in_t it;
    it.vx = vx; it.vy = vy; it.vz = vz;
    it.t = t; it.x = x; it.y = y; it.z = z;
    pending_items.push_back(it);
  endtask

  // A velocity component of random size up to the given magnitude, either sign.
  function automatic logic [31:0] rand_speed(input int unsigned lim);
    logic [31:0] m;
    m = $urandom_range(lim, 0);
    return $urandom_range(1, 0) ? -m : m;
  endfunction

  // Vector components: sometimes full-range words, mostly modest values so
  // that the boost does not simply clip.
  function automatic logic [31:0] rand_component();
    if ($urandom_range(2, 0) == 0) return $urandom;
    return rand_speed(32'h0100_0000);
  endfunction

  // Predict every accepted item at the edge that takes it.
  always @(posedge clk) begin
    boost_in_t it;
    if (rst_n && in_valid && in_ready) begin
      it.vx = in_vel_x; it.vy = in_vel_y; it.vz = in_vel_z;
      it.t = in_t; it.x = in_x; it.y = in_y; it.z = in_z;
      expected_boosts.push_back(boost_vector(it));
    end
  end

  // Driver: inputs move on the falling edge. The item stays put until the
  // rising edge before this one took it.
  bit took_item = 0;
  always @(posedge clk) took_item <= in_valid && in_ready && rst_n;

  always @(negedge clk) begin
    boost_in_t it;
    if (rst_n && (!in_valid || took_item)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0 && !finale && $urandom_range(11, 0) == 0) begin
        send_gap <= $urandom_range(18, 0);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_vel_x <= it.vx; in_vel_y <= it.vy; in_vel_z <= it.vz;
        in_t <= it.t; in_x <= it.x; in_y <= it.y; in_z <= it.z;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls in bursts too.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!finale && $urandom_range(9, 0) == 0) begin
        stall_left <= $urandom_range(18, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result item with the oldest expectation.
  always @(posedge clk) begin
    boost_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_boosts.size() == 0) begin
        $display("%0t: unexpected result item t=%h x=%h y=%h z=%h", $time,
                 out_t, out_x, out_y, out_z);
        mismatches++;
      end else begin
        e = expected_boosts.pop_front();
        if (out_t !== e.t) begin
          $display("%0t: out_t expected %h actual %h", $time, e.t, out_t);
          mismatches++;
        end
        if (out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
          mismatches++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
          mismatches++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
          mismatches++;
        end
        if (out_status !== e.status) begin
          $display("%0t: out_status expected %0d actual %0d", $time, e.status, out_status);
          mismatches++;
        end
        if (out_saturated !== e.sat) begin
          $display("%0t: out_saturated expected %0d actual %0d", $time, e.sat,
                   out_saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    {in_vel_x, in_vel_y, in_vel_z, in_t, in_x, in_y, in_z} = '0;

    // Directed items first: the zero velocity pass with extreme vectors, the
    // light-speed boundary from both sides, velocity words outside the
    // stated range, a tiny boost and boosts that clip.
    add_item(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    add_item(32'h4000_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0);
    add_item(0, 32'hC000_0000, 0, 32'h0001_0000, 0, 32'h0001_0000, 0);
    add_item(0, 0, 32'h7FFF_FFFF, 32'h1234_5678, 0, 0, 32'h1);
    add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 2, 3, 4);
    add_item(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 5, 6, 7, 8);
    add_item(32'h3FFF_FFFF, 0, 0, 32'h0002_0000, 32'h0001_0000, 0, 0);
    add_item(0, 32'hC000_0001, 0, 32'h0002_0000, 0, 32'hFFFF_0000, 0);
    add_item(0, 0, 32'h0000_0001, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h7FFF_FFFF);
    add_item(32'h3FFF_0000, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    add_item(0, 32'h3FFF_0000, 0, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(0, 0, 32'hC000_F000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(32'h2000_0000, 32'hE000_0000, 32'h1000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_item(32'h24F3_4E8B, 32'h24F3_4E8B, 32'h24F3_4E8B, 32'h0010_0000, 1, 1, 1);
    add_item(32'h1000_0000, 32'h1000_0000, 0, 32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'h0);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h2);

    // Random items: mostly physical speeds, with the boundary, the zero
    // velocity case and raw velocity words mixed in.
    repeat (1100) begin
      kind = $urandom_range(19, 0);
      case (kind)
        0: begin
          add_item(0, 0, 0, $urandom, $urandom, $urandom, $urandom);
        end
        1: begin
          add_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        2, 3: begin
          add_item(rand_speed(32'h4000_0000), rand_speed(32'h4000_0000),
                   rand_speed(32'h4000_0000), rand_component(), rand_component(),
                   rand_component(), rand_component());
        end
        4: begin
          add_item(rand_speed(32'h4000_0000) | 32'h3FF0_0000, rand_speed(32'h100),
                   rand_speed(32'h100), rand_component(), rand_component(),
                   rand_component(), rand_component());
        end
        default: begin
          add_item(rand_speed(32'h2000_0000), rand_speed(32'h2000_0000),
                   rand_speed(32'h2000_0000), rand_component(), rand_component(),
                   rand_component(), rand_component());
        end
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The last stretch of the run starts no new idle gaps or stalls on either side.
    wait (pending_items.size() < 100);
    finale = 1;
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_boosts.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
